[src/assert_macros.svh]
// assertion macros shared by the rtl
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define SHL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define SHL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[src/shl_pkg.sv]
// shared types and constants of the sonar height low-pass filter
// used by every module of the block, no dependencies
`default_nettype none

package shl_pkg;

  localparam int COEF_W         = 28;  // Q3.24 coefficients
  localparam int COEF_FRAC_BITS = 24;
  localparam int THRESH_W       = 23;
  localparam int HIST_W         = 32;  // Q7.24 output history
  localparam int HIST_FRAC      = 24;
  localparam int ACC_W          = 64;
  localparam int CMP_W          = 33;  // holds any sample and the threshold, signed
  localparam int CFG_IDX_W      = 4;
  localparam int WARM_W         = 2;
  localparam logic [WARM_W-1:0] WARM_DONE = 2'd2;

  // queue depth must stay a power of two, pointers wrap freely
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic signed [COEF_W-1:0] B1_RST = 28'sd28522;
  localparam logic signed [COEF_W-1:0] B2_RST = 28'sd87242;
  localparam logic signed [COEF_W-1:0] B3_RST = 28'sd87242;
  localparam logic signed [COEF_W-1:0] B4_RST = 28'sd28522;
  localparam logic signed [COEF_W-1:0] A2_RST = -28'sd41612529;
  localparam logic signed [COEF_W-1:0] A3_RST = 28'sd35017405;
  localparam logic signed [COEF_W-1:0] A4_RST = -28'sd9948889;
  localparam logic [THRESH_W-1:0]      THRESH_RST = 23'd655;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B1     = 4'd0,
    REG_B2     = 4'd1,
    REG_B3     = 4'd2,
    REG_B4     = 4'd3,
    REG_A2     = 4'd4,
    REG_A3     = 4'd5,
    REG_A4     = 4'd6,
    REG_THRESH = 4'd7
  } shl_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] b3;
    logic signed [COEF_W-1:0] b4;
  } shl_ff_coef_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] a3;
    logic signed [COEF_W-1:0] a4;
  } shl_fb_coef_t;

  // feedforward sum aligned to Q.(COEF_FRAC_BITS + 24)
  typedef struct packed {
    logic signed [ACC_W-1:0] ff;
    logic                    replaced;
  } shl_qent_t;

  typedef struct packed {
    logic busy;
    logic warm_done;
  } shl_front_sts_t;

endpackage

`default_nettype wire

[src/shl_fifo.sv]
// short queue between the front (feedforward) and back (feedback) parts
// depends on shl_pkg
`default_nettype none

module shl_fifo import shl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire shl_qent_t push_data,
  output logic           full,
  input  wire logic      pop,
  output shl_qent_t      head,
  output logic           empty
);

  shl_qent_t            mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic [Q_CNT_W-1:0]   cnt_nxt;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[src/shl_front.sv]
// front part: takes samples, replaces dropouts, keeps raw history and
// forms the registered feedforward products; depends on shl_pkg
`default_nettype none

module shl_front import shl_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_height,
  input  wire shl_ff_coef_t                   coef,
  input  wire logic [THRESH_W-1:0]            thresh,
  input  wire logic                           q_full,
  output logic                                q_push,
  output shl_qent_t                           q_data,
  output shl_front_sts_t                      sts
);

  localparam int ALIGN  = HIST_FRAC - (SAMPLE_WIDTH - 8);
  localparam int PROD_W = COEF_W + SAMPLE_WIDTH;

  logic                           accept;
  logic signed [CMP_W-1:0]        x_cmp;
  logic signed [CMP_W-1:0]        thr_cmp;
  logic                           dropout;
  logic signed [SAMPLE_WIDTH-1:0] x_sel;
  logic signed [COEF_W-1:0]       b1, b2, b3, b4;
  logic signed [SAMPLE_WIDTH-1:0] raw_r [3];
  logic [WARM_W-1:0]              warm_r;
  logic                           s1_vld_r;
  logic signed [PROD_W-1:0]       p_r [4];
  logic                           rep_r;
  logic signed [ACC_W-1:0]        ff_sum;

  assign b1 = coef.b1;
  assign b2 = coef.b2;
  assign b3 = coef.b3;
  assign b4 = coef.b4;

  assign in_stall = s1_vld_r & q_full;
  assign accept   = in_valid & ~in_stall;

  // negative samples always fall below the threshold
  assign x_cmp   = {{(CMP_W-SAMPLE_WIDTH){in_sample_height[SAMPLE_WIDTH-1]}}, in_sample_height};
  assign thr_cmp = {{(CMP_W-THRESH_W){1'b0}}, thresh};
  assign dropout = (warm_r == WARM_DONE) && (x_cmp < thr_cmp);
  assign x_sel   = dropout ? raw_r[0] : in_sample_height;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      warm_r   <= '0;
      raw_r[0] <= '0;
      raw_r[1] <= '0;
      raw_r[2] <= '0;
    end else begin
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (accept) begin
        raw_r[0] <= x_sel;
        raw_r[1] <= raw_r[0];
        raw_r[2] <= raw_r[1];
        if (warm_r != WARM_DONE) begin
          warm_r <= warm_r + 1'b1;
        end
      end
    end
  end

  // products use the history as it stood before this sample
  always_ff @(posedge clk) begin
    if (accept) begin
      p_r[0] <= b1 * x_sel;
      p_r[1] <= b2 * raw_r[0];
      p_r[2] <= b3 * raw_r[1];
      p_r[3] <= b4 * raw_r[2];
      rep_r  <= dropout;
    end
  end

  assign ff_sum = (ACC_W'(p_r[0]) + ACC_W'(p_r[1]) + ACC_W'(p_r[2]) + ACC_W'(p_r[3]))
                  <<< ALIGN;

  assign q_push          = s1_vld_r & ~q_full;
  assign q_data.ff       = ff_sum;
  assign q_data.replaced = rep_r;

  assign sts.busy      = s1_vld_r;
  assign sts.warm_done = (warm_r == WARM_DONE);

endmodule

`default_nettype wire

[src/shl_back.sv]
// back part: feedback products, rounding, saturation, output history
// and the output register; depends on shl_pkg
`default_nettype none

module shl_back import shl_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_empty,
  input  wire shl_qent_t                q_head,
  output logic                          q_pop,
  input  wire shl_fb_coef_t             coef,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_filtered_height,
  output logic                          out_sample_replaced
);

  localparam int ALIGN  = HIST_FRAC - (SAMPLE_WIDTH - 8);
  localparam int FB_W   = COEF_W + HIST_W;
  localparam int YSH_W  = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND_ACC = (ACC_W'(1) << COEF_FRAC_BITS) >> 1;
  localparam logic signed [HIST_W:0]  RND_OUT = ((HIST_W+1)'(1) << ALIGN) >> 1;
  localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_W-1:0]       a2, a3, a4;
  logic signed [HIST_W-1:0]       y_r [3];
  logic signed [FB_W-1:0]         f2, f3, f4;
  logic signed [ACC_W-1:0]        acc;
  logic signed [YSH_W-1:0]        y_sh;
  logic                           y_fits;
  logic signed [HIST_W-1:0]       y_sat;
  logic signed [HIST_W:0]         o_t;
  logic signed [SAMPLE_WIDTH:0]   o_sh;
  logic signed [SAMPLE_WIDTH-1:0] o_sat;
  logic                           out_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] out_fh_r;
  logic                           out_rep_r;

  assign a2 = coef.a2;
  assign a3 = coef.a3;
  assign a4 = coef.a4;

  assign q_pop = ~q_empty & (~out_vld_r | ~out_stall);

  assign f2 = a2 * y_r[0];
  assign f3 = a3 * y_r[1];
  assign f4 = a4 * y_r[2];

  // round half up to Q7.24, then saturate to the history width
  assign acc    = q_head.ff - (ACC_W'(f2) + ACC_W'(f3) + ACC_W'(f4)) + RND_ACC;
  assign y_sh   = acc[ACC_W-1:COEF_FRAC_BITS];
  assign y_fits = (&y_sh[YSH_W-1:HIST_W-1]) | ~(|y_sh[YSH_W-1:HIST_W-1]);
  assign y_sat  = y_fits ? y_sh[HIST_W-1:0] : (y_sh[YSH_W-1] ? HIST_MIN : HIST_MAX);

  // same rounding down to the sample fraction
  assign o_t   = {y_sat[HIST_W-1], y_sat} + RND_OUT;
  assign o_sh  = o_t[HIST_W:ALIGN];
  assign o_sat = (o_sh[SAMPLE_WIDTH] == o_sh[SAMPLE_WIDTH-1]) ? o_sh[SAMPLE_WIDTH-1:0] :
                 (o_sh[SAMPLE_WIDTH] ? OUT_MIN : OUT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      y_r[0]    <= '0;
      y_r[1]    <= '0;
      y_r[2]    <= '0;
    end else begin
      if (q_pop) begin
        out_vld_r <= 1'b1;
        y_r[0]    <= y_sat;
        y_r[1]    <= y_r[0];
        y_r[2]    <= y_r[1];
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_fh_r  <= o_sat;
      out_rep_r <= q_head.replaced;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_filtered_height = out_fh_r;
  assign out_sample_replaced = out_rep_r;

endmodule

`default_nettype wire

[src/sonar_height_iir_lowpass.sv]
// sonar height filter: third-order direct-form-I low-pass with dropout fill
// top level; holds the register file and ties front, queue and back together
// depends on shl_pkg, shl_front, shl_fifo, shl_back, assert_macros.svh
//
// Usage:
//   in_*  : one signed Q7.(SAMPLE_WIDTH-8) height per transaction; a transaction
//           completes on a clock edge with in_valid high and in_stall low.
//   out_* : one filtered height and a replaced flag per input transaction,
//           in order, same handshake with out_stall driven by the receiver.
//   cfg_* : register writes by index (0..3 b1..b4, 4..6 a2..a4, 7 threshold),
//           cfg_ready is always high; write only while the block is idle.
// Transactions pass the front stage, queue and output register to out_valid.
// Throughput is one per cycle while out_stall is low, set by the feedback loop
// through the three output-history multipliers and rounding/saturation adder.
// A 2-entry queue sits between the feedforward front and the feedback back,
// so a stall on out_stall fills the output register, the queue, and then the
// front stage before in_stall rises; nothing is lost.
// Reset (synchronous, active low) clears histories and warm-up count and
// loads the default coefficients and threshold.
`default_nettype none

module sonar_height_iir_lowpass import shl_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_height,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_filtered_height,
  output logic                                out_sample_replaced,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [COEF_W-1:0]              cfg_data
);

`include "assert_macros.svh"

  logic                     cfg_we;
  logic signed [COEF_W-1:0] b1_r, b2_r, b3_r, b4_r;
  logic signed [COEF_W-1:0] a2_r, a3_r, a4_r;
  logic [THRESH_W-1:0]      thresh_r;
  shl_ff_coef_t             ff_coef;
  shl_fb_coef_t             fb_coef;
  logic                     q_push;
  logic                     q_pop;
  logic                     q_full;
  logic                     q_empty;
  shl_qent_t                q_in;
  shl_qent_t                q_head;
  shl_front_sts_t           fr_sts;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r     <= B1_RST;
      b2_r     <= B2_RST;
      b3_r     <= B3_RST;
      b4_r     <= B4_RST;
      a2_r     <= A2_RST;
      a3_r     <= A3_RST;
      a4_r     <= A4_RST;
      thresh_r <= THRESH_RST;
    end else if (cfg_we) begin
      case (shl_reg_t'(cfg_index))
        REG_B1:     b1_r     <= cfg_data;
        REG_B2:     b2_r     <= cfg_data;
        REG_B3:     b3_r     <= cfg_data;
        REG_B4:     b4_r     <= cfg_data;
        REG_A2:     a2_r     <= cfg_data;
        REG_A3:     a3_r     <= cfg_data;
        REG_A4:     a4_r     <= cfg_data;
        REG_THRESH: thresh_r <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign ff_coef = '{b1: b1_r, b2: b2_r, b3: b3_r, b4: b4_r};
  assign fb_coef = '{a2: a2_r, a3: a3_r, a4: a4_r};

  shl_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_height (in_sample_height),
    .coef             (ff_coef),
    .thresh           (thresh_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_in),
    .sts              (fr_sts)
  );

  shl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  shl_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .coef                (fb_coef),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_height (out_filtered_height),
    .out_sample_replaced (out_sample_replaced)
  );

  // accepted sample must sit in the front stage on the next cycle
  `SHL_ASSERT(a_accept_to_stage, (in_valid && !in_stall) |=> fr_sts.busy, "accepted sample lost in front")
  // a replaced sample can only reach the back after warm-up
  `SHL_ASSERT(a_replace_warm, (q_pop && q_head.replaced) |-> fr_sts.warm_done, "replacement before warm-up")
  // a full queue that is not drained must stay full
  `SHL_ASSERT(a_queue_hold, (q_full && !q_pop) |=> q_full, "queue entry dropped")
  `SHL_NEVER(a_stage_drop, fr_sts.busy && !q_push && !in_stall, "front stage overwritten")

endmodule

`default_nettype wire
